### src/rgbcal_pkg.sv
package rgbcal_pkg;

  // Field and register widths
  localparam int ADC_W       = 10;
  localparam int DELAY_W     = 16;
  localparam int ROUNDS_W    = 4;
  localparam int LEVEL_W     = 8;
  localparam int PHASE_W     = 2;
  localparam int LED_W       = 3;
  localparam int CH_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 10;

  // Register reset values
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd100;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd5;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_DELAY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_PER_TARGET = 2'd1;

  // Target phases
  localparam logic [PHASE_W-1:0] PH_WHITE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BLACK  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COLOUR = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SPARE  = 2'd3;

  // LED channel indexes
  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

  // Active-low LED patterns
  localparam logic [LED_W-1:0] LED_OFF   = 3'b111;
  localparam logic [LED_W-1:0] LED_RED   = 3'b110;
  localparam logic [LED_W-1:0] LED_GREEN = 3'b101;
  localparam logic [LED_W-1:0] LED_BLUE  = 3'b011;

  // Controller -> datapath
  typedef struct packed {
    logic            tick;     // apply one accepted tick
    logic            setup;    // latch differences for channel ch
    logic            scale;    // form numerator and shifted divisor
    logic            step;     // one restoring division step
    logic            store;    // write level for channel ch
    logic            load;     // capture output transaction
    logic            ready;    // colour_ready bit of that transaction
    logic [CH_W-1:0] ch;
  } rgbcal_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic calc_req;            // this tick finishes the colour target
  } rgbcal_stat_t;

endpackage

### src/rgbcal_in_if.sv
interface rgbcal_in_if;
  import rgbcal_pkg::*;

  logic             valid;
  logic             ready;
  logic             button_level;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, button_level, adc_sample, input ready);
  modport sink   (input valid, button_level, adc_sample, output ready);
endinterface

### src/rgbcal_out_if.sv
interface rgbcal_out_if;
  import rgbcal_pkg::*;

  logic               valid;
  logic               ready;
  logic [LED_W-1:0]   led_drive;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  logic [PHASE_W-1:0] phase;
  logic               colour_ready;

  modport source (output valid, led_drive, red_level, green_level, blue_level, phase,
                  colour_ready, input ready);
  modport sink   (input valid, led_drive, red_level, green_level, blue_level, phase,
                  colour_ready, output ready);
endinterface

### src/rgb_colour_sensor_calibrator_unit.sv
// Flow: an accepted tick updates the run state, then the EMIT state loads its result
//   transaction; a tick that ends the colour run first passes SETUP, SCALE, ITER, STORE
//   per channel on the 8-step restoring divider shared across the three channels. No new
//   tick is taken until the last result is loaded and the output slot is free or draining.
// Reset: rst_ni async active low; registers return to defaults, sums and levels
//   clear, delay counter loads 100, all LEDs off, no transaction pending.
module rgb_colour_sensor_calibrator_unit #(
  parameter int SAMPLE_BITS = rgbcal_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port: index 0 measure_delay, 1 rounds_per_target
  input  logic                              cfg_we_i,
  input  logic [rgbcal_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgbcal_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // One transaction per timer tick in, one result transaction out
  rgbcal_in_if.sink                         sample_ch,
  rgbcal_out_if.source                      result_ch
);
  import rgbcal_pkg::*;

  rgbcal_cmd_t  cmd;
  rgbcal_stat_t stat;

  // Controller: sequences tick, division steps and the output register.
  // Input ready only while idle and the output slot is free or draining.
  rgbcal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_ch.valid),
    .in_ready_o  (sample_ch.ready),
    .out_valid_o (result_ch.valid),
    .out_ready_i (result_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: run/delay state, per-target sums, level divider, output payload.
  rgbcal_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .button_level_i (sample_ch.button_level),
    .adc_sample_i   (sample_ch.adc_sample),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .led_drive_o    (result_ch.led_drive),
    .red_level_o    (result_ch.red_level),
    .green_level_o  (result_ch.green_level),
    .blue_level_o   (result_ch.blue_level),
    .phase_o        (result_ch.phase),
    .colour_ready_o (result_ch.colour_ready)
  );

endmodule

### src/rgbcal_ctrl.sv
module rgbcal_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  rgbcal_pkg::rgbcal_stat_t stat_i,
  output rgbcal_pkg::rgbcal_cmd_t  cmd_o
);
  import rgbcal_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;
  localparam logic [2:0] S_EMITC = 3'd6;

  localparam int          ITER_N = LEVEL_W;
  localparam int          ITER_W = $clog2(ITER_N);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ITER_N - 1);

  logic [2:0]        state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;

  // Output register is free or being emptied this cycle
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.tick = 1'b1;
          ch_d       = CH_RED;
          state_d    = stat_i.calc_req ? S_SETUP : S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.load  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        iter_d      = '0;
        state_d     = S_ITER;
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        iter_d     = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (ch_q == CH_BLUE) begin
          state_d = S_EMITC;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = S_SETUP;
        end
      end
      S_EMITC: begin
        cmd_o.load  = 1'b1;
        cmd_o.ready = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_RED;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/rgbcal_datapath.sv
module rgbcal_datapath #(
  parameter int SAMPLE_BITS = rgbcal_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rgbcal_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rgbcal_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                               button_level_i,
  input  logic [rgbcal_pkg::ADC_W-1:0]       adc_sample_i,
  input  rgbcal_pkg::rgbcal_cmd_t            cmd_i,
  output rgbcal_pkg::rgbcal_stat_t           stat_o,
  output logic [rgbcal_pkg::LED_W-1:0]       led_drive_o,
  output logic [rgbcal_pkg::LEVEL_W-1:0]     red_level_o,
  output logic [rgbcal_pkg::LEVEL_W-1:0]     green_level_o,
  output logic [rgbcal_pkg::LEVEL_W-1:0]     blue_level_o,
  output logic [rgbcal_pkg::PHASE_W-1:0]     phase_o,
  output logic                               colour_ready_o
);
  import rgbcal_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 4;
  localparam int WIDE_W = SUM_W + ADC_W;
  localparam int TAKE_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
  localparam logic [WIDE_W-1:0] SAMPLE_MASK = WIDE_W'((64'd1 << TAKE_W) - 64'd1);
  localparam int NUM_W  = SUM_W + LEVEL_W;

  // Configuration
  logic [DELAY_W-1:0]  md_q;
  logic [ROUNDS_W-1:0] rpt_q;

  // Tick state
  logic [DELAY_W-1:0]  dly_q, dly_d;
  logic                run_q, run_d;
  logic [CH_W-1:0]     idx_q, idx_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [ROUNDS_W-1:0] rounds_q, rounds_d;
  logic [LED_W-1:0]    mask_q, mask_d;
  logic                prev_q;
  logic [2:0][SUM_W-1:0]   white_q, white_d;
  logic [2:0][SUM_W-1:0]   black_q, black_d;
  logic [2:0][SUM_W-1:0]   colour_q, colour_d;
  logic [2:0][LEVEL_W-1:0] lvl_q, lvl_d;

  // Division unit
  logic [SUM_W-1:0]   diff_q, span_q;
  logic               spec_q;
  logic [LEVEL_W-1:0] spec_val_q;
  logic [NUM_W-1:0]   rem_q, dsh_q;
  logic [LEVEL_W-1:0] quo_q;

  // Output register
  logic [LED_W-1:0]        o_led_q;
  logic [2:0][LEVEL_W-1:0] o_lvl_q;
  logic [PHASE_W-1:0]      o_phase_q;
  logic                    o_rdy_q;

  logic [WIDE_W-1:0] sample_wide;
  logic [SUM_W-1:0]  sample;
  logic              start, take, finish;
  logic [SUM_W-1:0]  c_sel, b_sel, w_sel;

  assign sample_wide = {{SUM_W{1'b0}}, adc_sample_i} & SAMPLE_MASK;
  assign sample      = sample_wide[SUM_W-1:0];

  // One timer tick
  always_comb begin
    dly_d    = dly_q;
    run_d    = run_q;
    idx_d    = idx_q;
    phase_d  = phase_q;
    rounds_d = rounds_q;
    mask_d   = mask_q;
    white_d  = white_q;
    black_d  = black_q;
    colour_d = colour_q;
    lvl_d    = lvl_q;
    take     = 1'b0;
    finish   = 1'b0;
    start    = prev_q && !button_level_i;

    if (start) begin
      run_d = 1'b1;
      dly_d = md_q;
      if (phase_q == PH_COLOUR || phase_q == PH_SPARE) begin
        phase_d  = PH_COLOUR;
        colour_d = '0;
        lvl_d    = '0;
      end
    end

    if (dly_d == '0 && !run_d) begin
      mask_d = LED_OFF;
    end

    dly_d = dly_d - DELAY_W'(1);
    if (dly_d == '0 && run_d) begin
      case (idx_q)
        CH_RED: begin
          mask_d = LED_RED;
          take   = 1'b1;
        end
        CH_GREEN: begin
          mask_d = LED_GREEN;
          take   = 1'b1;
        end
        CH_BLUE: begin
          mask_d   = LED_BLUE;
          rounds_d = rounds_d + ROUNDS_W'(1);
          take     = 1'b1;
        end
        default: ;
      endcase
      dly_d = md_q;
    end

    if (take) begin
      case (phase_d)
        PH_WHITE:  white_d[idx_q]  = white_d[idx_q] + sample;
        PH_BLACK:  black_d[idx_q]  = black_d[idx_q] + sample;
        PH_COLOUR: colour_d[idx_q] = colour_d[idx_q] + sample;
        default: ;
      endcase
      idx_d = (idx_q == CH_BLUE) ? CH_RED : idx_q + CH_W'(1);
      if (rounds_d == rpt_q) begin
        finish   = (phase_d == PH_COLOUR);
        rounds_d = '0;
        run_d    = 1'b0;
        dly_d    = md_q;
        if (phase_d == PH_WHITE || phase_d == PH_BLACK) begin
          phase_d = phase_d + PHASE_W'(1);
        end
      end
    end
  end

  assign stat_o.calc_req = finish;

  // Channel select for the level calculation
  always_comb begin
    case (cmd_i.ch)
      CH_RED: begin
        c_sel = colour_q[0];
        b_sel = black_q[0];
        w_sel = white_q[0];
      end
      CH_GREEN: begin
        c_sel = colour_q[1];
        b_sel = black_q[1];
        w_sel = white_q[1];
      end
      default: begin
        c_sel = colour_q[2];
        b_sel = black_q[2];
        w_sel = white_q[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q     <= DELAY_RESET;
      rpt_q    <= ROUNDS_RESET;
      dly_q    <= DELAY_RESET;
      run_q    <= 1'b0;
      idx_q    <= CH_RED;
      phase_q  <= PH_WHITE;
      rounds_q <= '0;
      mask_q   <= LED_OFF;
      prev_q   <= 1'b0;
      white_q  <= '0;
      black_q  <= '0;
      colour_q <= '0;
      lvl_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MEASURE_DELAY:     md_q  <= cfg_wdata_i[DELAY_W-1:0];
          CFG_ROUNDS_PER_TARGET: rpt_q <= cfg_wdata_i[ROUNDS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.tick) begin
        dly_q    <= dly_d;
        run_q    <= run_d;
        idx_q    <= idx_d;
        phase_q  <= phase_d;
        rounds_q <= rounds_d;
        mask_q   <= mask_d;
        prev_q   <= button_level_i;
        white_q  <= white_d;
        black_q  <= black_d;
        colour_q <= colour_d;
        lvl_q    <= lvl_d;
      end
      if (cmd_i.store) begin
        lvl_q[cmd_i.ch] <= spec_q ? spec_val_q : quo_q;
      end
    end
  end

  // Level = floor((c-b)*255/(w-b)), clamped; quotient never exceeds 8 bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      diff_q <= c_sel - b_sel;
      span_q <= w_sel - b_sel;
      if (c_sel < b_sel) begin
        spec_q     <= 1'b1;
        spec_val_q <= '0;
      end else if (c_sel > w_sel) begin
        spec_q     <= 1'b1;
        spec_val_q <= LEVEL_MAX;
      end else if (w_sel == b_sel) begin
        spec_q     <= 1'b1;
        spec_val_q <= '0;
      end else begin
        spec_q     <= 1'b0;
        spec_val_q <= '0;
      end
    end
    if (cmd_i.scale) begin
      rem_q <= {diff_q, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, diff_q};
      dsh_q <= {1'b0, span_q, {(LEVEL_W-1){1'b0}}};
      quo_q <= '0;
    end
    if (cmd_i.step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[LEVEL_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[LEVEL_W-2:0], 1'b0};
      end
      dsh_q <= {1'b0, dsh_q[NUM_W-1:1]};
    end
    if (cmd_i.load) begin
      o_led_q   <= mask_q;
      o_lvl_q   <= lvl_q;
      o_phase_q <= phase_q;
      o_rdy_q   <= cmd_i.ready;
    end
  end

  assign led_drive_o    = o_led_q;
  assign red_level_o    = o_lvl_q[0];
  assign green_level_o  = o_lvl_q[1];
  assign blue_level_o   = o_lvl_q[2];
  assign phase_o        = o_phase_q;
  assign colour_ready_o = o_rdy_q;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rgbcal_pkg::*;

  // Sum width follows the sample width plus four bits of headroom
  localparam int SUM_W          = SAMPLE_BITS_DEF + 4;
  localparam int TOTAL_TICKS    = 650;
  localparam int CALM_TICKS     = 100;   // last stretch runs with no idling
  localparam int SETTLE_CYCLES  = 40;    // covers the colour calculation
  localparam int HOLDOFF_CYCLES = 300;   // long receiver stall, fills the block
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side

  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED3 = 2'd3;

  typedef struct packed {
    logic [LED_W-1:0]   led_drive;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [PHASE_W-1:0] phase;
    logic               colour_ready;
  } cal_reading_t;

  // Tracks the calibrator state per accepted tick and holds the readings
  // the block owes us, oldest first.
  class calibration_tracker;
    logic [DELAY_W-1:0]  delay_reload;
    logic [ROUNDS_W-1:0] rounds_target;
    logic [DELAY_W-1:0]  delay_cnt;
    logic                running;
    logic [CH_W-1:0]     channel;
    logic [PHASE_W-1:0]  target;
    logic [ROUNDS_W-1:0] rounds_cnt;
    logic [LED_W-1:0]    leds;
    logic                prev_btn;
    logic [SUM_W-1:0]    white_acc [3];
    logic [SUM_W-1:0]    black_acc [3];
    logic [SUM_W-1:0]    colour_acc [3];
    logic [LEVEL_W-1:0]  levels [3];
    cal_reading_t        expected_readings [$];
    int errors;
    int ticks;
    int readings;
    int colour_done;

    function new();
      delay_reload  = DELAY_RESET;
      rounds_target = ROUNDS_RESET;
      delay_cnt     = DELAY_RESET;
      running       = 1'b0;
      channel       = CH_RED;
      target        = PH_WHITE;
      rounds_cnt    = '0;
      leds          = LED_OFF;
      prev_btn      = 1'b0;
      for (int i = 0; i < 3; i++) begin
        white_acc[i]  = '0;
        black_acc[i]  = '0;
        colour_acc[i] = '0;
        levels[i]     = '0;
      end
      errors      = 0;
      ticks       = 0;
      readings    = 0;
      colour_done = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MEASURE_DELAY:     delay_reload  = data[DELAY_W-1:0];
        CFG_ROUNDS_PER_TARGET: rounds_target = data[ROUNDS_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_readings.size();
    endfunction

    function logic [LEVEL_W-1:0] scale_level(int unsigned c, int unsigned b, int unsigned w);
      int unsigned span;
      if (c < b) return '0;
      if (c > w) return LEVEL_MAX;
      span = w - b;
      if (span == 0) return '0;
      return LEVEL_W'(((c - b) * 255) / span);
    endfunction

    function void note_tick(logic btn, logic [ADC_W-1:0] smp);
      logic         take;
      logic         ready;
      cal_reading_t want;
      take  = 1'b0;
      ready = 1'b0;

      // falling button edge (re)starts a run; a colour restart clears results
      if (prev_btn && !btn) begin
        running   = 1'b1;
        delay_cnt = delay_reload;
        if (target >= PH_COLOUR) begin
          target = PH_COLOUR;
          for (int i = 0; i < 3; i++) begin
            colour_acc[i] = '0;
            levels[i]     = '0;
          end
        end
      end

      if (delay_cnt == 0 && !running) leds = LED_OFF;

      delay_cnt = delay_cnt - DELAY_W'(1);
      if (delay_cnt == 0 && running) begin
        case (channel)
          CH_RED:   begin leds = LED_RED;   take = 1'b1; end
          CH_GREEN: begin leds = LED_GREEN; take = 1'b1; end
          CH_BLUE: begin
            leds       = LED_BLUE;
            rounds_cnt = rounds_cnt + ROUNDS_W'(1);
            take       = 1'b1;
          end
          default: ;
        endcase
        delay_cnt = delay_reload;
      end

      if (take) begin
        case (target)
          PH_WHITE:  white_acc[channel]  = white_acc[channel] + SUM_W'(smp);
          PH_BLACK:  black_acc[channel]  = black_acc[channel] + SUM_W'(smp);
          PH_COLOUR: colour_acc[channel] = colour_acc[channel] + SUM_W'(smp);
          default: ;
        endcase
        channel = (channel == CH_BLUE) ? CH_RED : channel + CH_W'(1);

        // target done: rounds match (wraps mod 16 if lowered mid-run)
        if (rounds_cnt == rounds_target) begin
          if (target == PH_COLOUR) begin
            for (int i = 0; i < 3; i++)
              levels[i] = scale_level(32'(colour_acc[i]), 32'(black_acc[i]),
                                      32'(white_acc[i]));
            ready = 1'b1;
          end
          rounds_cnt = '0;
          running    = 1'b0;
          delay_cnt  = delay_reload;
          if (target < PH_COLOUR) target = target + PHASE_W'(1);
        end
      end

      prev_btn = btn;

      want.led_drive    = leds;
      want.red          = levels[0];
      want.green        = levels[1];
      want.blue         = levels[2];
      want.phase        = target;
      want.colour_ready = ready;
      expected_readings.push_back(want);
      ticks++;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want, int idx);
      if (got != want)
        report($sformatf("result %0d %s: got %0d, expected %0d", idx, name, got, want));
    endtask

    task check_result(cal_reading_t got);
      cal_reading_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", readings));
      end else begin
        want = expected_readings.pop_front();
        compare_field("led_drive", int'(got.led_drive), int'(want.led_drive), readings);
        compare_field("red_level", int'(got.red), int'(want.red), readings);
        compare_field("green_level", int'(got.green), int'(want.green), readings);
        compare_field("blue_level", int'(got.blue), int'(want.blue), readings);
        compare_field("phase", int'(got.phase), int'(want.phase), readings);
        compare_field("colour_ready", int'(got.colour_ready), int'(want.colour_ready),
                      readings);
        if (want.colour_ready) colour_done++;
      end
      readings++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rgbcal_in_if  sample_if ();
  rgbcal_out_if result_if ();

  rgb_colour_sensor_calibrator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_ch   (sample_if),
    .result_ch   (result_if)
  );

  calibration_tracker tracker;

  int items_sent;
  int cfg_writes;
  int idle_cycles;
  bit calm;      // set for the final stretch: no idling on either side
  bit hold_req;  // asks the receiver for one long hold-off

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Result monitor and watchdog. Sampled at the rising edge; a result
  // transaction is checked against the oldest pending reading.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    cal_reading_t got;
    logic         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got.led_drive    = result_if.led_drive;
        got.red          = result_if.red_level;
        got.green        = result_if.green_level;
        got.blue         = result_if.blue_level;
        got.phase        = result_if.phase;
        got.colour_ready = result_if.colour_ready;
        tracker.check_result(got);
        moved = 1'b1;
      end
      if (sample_if.valid && sample_if.ready) moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d readings pending",
               idle_cycles, tracker.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge. Random stall bursts, one long
  // hold-off on request, and no random stalls once calm is set.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk_i);
      end else if (rst_ni && !calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(0, 5);
        result_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Offer one tick transaction, optionally after an idle burst; returns at
  // the falling edge after it was accepted. valid stays high for the next one.
  task automatic send_tick(input logic btn, input logic [ADC_W-1:0] smp);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      sample_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_if.valid        <= 1'b1;
    sample_if.button_level <= btn;
    sample_if.adc_sample   <= smp;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    tracker.note_tick(btn, smp);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every reading has come back, then let the
  // divider settle.
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    tracker.apply_write(idx, val);
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Light samples lean on the extremes
  function automatic logic [ADC_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int  dly;
    int  rnds;
    int  budget;
    int  phase_end;
    int  len;
    bit  hold;
    bit  hold_done;
    bit  drain_done;

    tracker     = new();
    items_sent  = 0;
    cfg_writes  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    drain_done  = 1'b0;

    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_MEASURE_DELAY;
    cfg_wdata_i            = '0;
    sample_if.valid        = 1'b0;
    sample_if.button_level = 1'b1;
    sample_if.adc_sample   = '0;

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- Directed part ------------------------------------------------------
    // delay 1: every tick of a run lights the next LED; two rounds per target.
    write_reg(CFG_MEASURE_DELAY, 16'd1);
    write_reg(CFG_ROUNDS_PER_TARGET, 16'd2);
    // indexes past the register list are ignored
    write_reg(CFG_IDX_UNUSED2, 16'hFFFF);
    write_reg(CFG_IDX_UNUSED3, 16'h0000);

    // White target: red 500, green full scale, blue 700 per round
    send_tick(1'b1, 10'd0);
    send_tick(1'b0, 10'd500);
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd700);
    send_tick(1'b1, 10'd500);
    send_tick(1'b1, 10'd1023);
    send_tick(1'b1, 10'd700);

    // Black target with a restart in the middle of the round; red matches
    // white so its span is zero, green is 0, blue 100
    send_tick(1'b0, 10'd500);
    send_tick(1'b1, 10'd0);
    send_tick(1'b0, 10'd100);
    send_tick(1'b1, 10'd500);
    send_tick(1'b1, 10'd0);
    send_tick(1'b1, 10'd100);

    // Colour target: red above white, green mid-scale, blue between black and white
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd0);
    send_tick(1'b0, 10'd150);
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd1023);
    send_tick(1'b0, 10'd1023);
    // idle afterwards: LEDs go dark once the delay count runs out
    send_tick(1'b1, 10'd1023);
    send_tick(1'b1, 10'd0);

    // Zero rounds: the run ends on its first sample (below black)
    write_reg(CFG_ROUNDS_PER_TARGET, 16'd0);
    send_tick(1'b0, 10'd300);
    send_tick(1'b1, 10'd0);

    // --- Random part --------------------------------------------------------
    // Each pass picks a setting, then mostly well-formed press-and-measure
    // sequences with random content, plus button noise. Pass boundaries fall
    // mid-run, so settings also change with a run in progress.
    while (items_sent < TOTAL_TICKS) begin
      case ($urandom_range(0, 9))
        0:       dly = 65535;
        1:       dly = 0;      // reload of 0 wraps to a 65536-tick period
        2:       dly = $urandom_range(4, 20);
        default: dly = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 7))
        0:       rnds = 15;
        1:       rnds = 0;
        default: rnds = $urandom_range(1, 4);
      endcase
      write_reg(CFG_MEASURE_DELAY, CFG_DATA_W'(dly));
      write_reg(CFG_ROUNDS_PER_TARGET, CFG_DATA_W'(rnds));

      // long periods never reach a step here, keep those passes short
      budget    = (dly == 0 || dly > 20) ? 12 : $urandom_range(30, 80);
      phase_end = items_sent + budget;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 3) != 0) begin
          send_tick(1'b1, pick_sample());
          send_tick(1'b0, pick_sample());
          hold = $urandom_range(0, 1);
          len  = dly * 3 * ((rnds == 0) ? 1 : rnds) + $urandom_range(0, 4);
          for (int k = 0; k < len && items_sent < phase_end; k++)
            send_tick(hold, pick_sample());
        end else begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++)
            send_tick(1'(($urandom_range(0, 1))), pick_sample());
        end
        // receiver holds off while ticks keep coming
        if (!hold_done && items_sent >= 220) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end

      // one sender pause until everything is back
      if (!drain_done && items_sent >= 400) begin
        drain();
        drain_done = 1'b1;
      end
      if (items_sent >= TOTAL_TICKS - CALM_TICKS) calm = 1'b1;
    end

    // --- Wind-down ----------------------------------------------------------
    sample_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d ticks and %0d results, %0d of them with fresh colour levels,",
             tracker.ticks, tracker.readings, tracker.colour_done);
    $display("over %0d register writes spanning zero and full-range delays and rounds.",
             cfg_writes);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
